// ===== hdl/lgal_pkg.sv =====
package lgal_pkg;

    localparam int unsigned MAX_POPS_DEF    = 16;
    localparam int unsigned MAX_ALLELES_DEF = 64;
    localparam int unsigned MAX_SAMPLES_DEF = 4096;

    localparam int unsigned THETA_W   = 24;
    localparam int unsigned TERM_W    = 22;
    localparam int unsigned TOTAL_W   = 34;
    localparam int unsigned SUM_W     = 35;
    localparam int unsigned LN_W      = 25;
    localparam int unsigned MANT_W    = 31;
    localparam int unsigned FRAC_W    = 20;
    localparam int unsigned EXP_W     = 7;
    localparam int unsigned POP_IN_W  = 4;
    localparam int unsigned AL_IN_W   = 6;

    localparam logic [THETA_W-1:0] THETA_RESET = 24'd65536;
    localparam logic [31:0]        LN2_Q32     = 32'd2977044472;

    typedef struct packed {
        logic is_global;
        logic first;
        logic last;
    } t_flags;

endpackage

// ===== hdl/lgal_front.sv =====
module lgal_front
    import lgal_pkg::*;
#(
    parameter int unsigned MAX_POPS    = MAX_POPS_DEF,
    parameter int unsigned MAX_ALLELES = MAX_ALLELES_DEF,
    parameter int unsigned PW = (MAX_POPS > 1) ? $clog2(MAX_POPS) : 1,
    parameter int unsigned AW = $clog2(MAX_ALLELES),
    parameter int unsigned LW = $clog2(MAX_POPS * MAX_ALLELES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [POP_IN_W-1:0] i_population,
    input  logic [AL_IN_W-1:0]  i_allele,
    input  logic                i_is_global,
    input  logic                i_first_item,
    input  logic                i_last_item,
    input  logic                i_enable,
    output logic                o_q_valid,
    input  logic                i_q_pop,
    output logic [PW-1:0]       o_q_pop_idx,
    output logic [AW-1:0]       o_q_al_idx,
    output logic [LW-1:0]       o_q_loc_idx,
    output t_flags              o_q_flags
);

    localparam int unsigned QW = PW + AW + LW + 3;

    logic [PW-1:0] pop_tab [2**POP_IN_W];
    logic [AW-1:0] al_tab  [2**AL_IN_W];

    for (genvar g = 0; g < 2**POP_IN_W; g++) begin : g_pt
        localparam int unsigned V = g % MAX_POPS;
        assign pop_tab[g] = PW'(V);
    end
    for (genvar g = 0; g < 2**AL_IN_W; g++) begin : g_at
        localparam int unsigned V = g % MAX_ALLELES;
        assign al_tab[g] = AW'(V);
    end

    logic [PW-1:0] pop_idx;
    logic [AW-1:0] al_idx;
    logic [LW-1:0] loc_idx;
    logic [QW-1:0] q_din;
    logic [QW-1:0] r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic [QW-1:0] q_head;

    assign pop_idx = pop_tab[i_population];
    assign al_idx  = al_tab[i_allele];
    assign loc_idx = LW'(pop_idx * MAX_ALLELES) + LW'(al_idx);
    assign q_din   = {pop_idx, al_idx, loc_idx, i_is_global, i_first_item, i_last_item};

    assign o_ready   = i_enable && (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign q_head    = r_q[r_rp];
    assign {o_q_pop_idx, o_q_al_idx, o_q_loc_idx, o_q_flags} = q_head;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= q_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

// ===== hdl/lgal_log.sv =====
module lgal_log
    import lgal_pkg::*;
#(
    parameter int unsigned NW = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NW-1:0]          i_value,
    output logic                   o_done,
    output logic signed [LN_W-1:0] o_result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NORM = 5'b00010,
        S_SQ   = 5'b00100,
        S_MUL  = 5'b01000,
        S_RND  = 5'b10000
    } t_lstate;

    t_lstate                  r_state;
    logic [NW-1:0]            r_n;
    logic signed [EXP_W-1:0]  r_e;
    logic [MANT_W-1:0]        r_x;
    logic [FRAC_W-1:0]        r_f;
    logic [4:0]               r_i;
    logic [58:0]              r_prod;
    logic                     r_neg;
    logic                     r_done;
    logic signed [LN_W-1:0]   r_res;

    logic [61:0]              sq_full;
    logic [31:0]              sq;
    logic signed [26:0]       l2;
    logic [26:0]              mag;
    logic [58:0]              rsum;
    logic [22:0]              q;

    assign sq_full  = {31'd0, r_x} * {31'd0, r_x};
    assign sq       = sq_full[61:30];
    assign l2       = {r_e, r_f};
    assign mag      = l2[26] ? 27'(-l2) : 27'(l2);
    assign rsum     = r_prod + (59'd1 << 35);
    assign q        = rsum[58:36];
    assign o_done   = r_done;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= (i_value == '0) ? NW'(1) : i_value;
                        r_e     <= EXP_W'(NW - 17);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_n[NW-1]) begin
                        r_x     <= r_n[NW-1 -: MANT_W];
                        r_i     <= 5'(FRAC_W - 1);
                        r_state <= S_SQ;
                    end else begin
                        r_n <= {r_n[NW-2:0], 1'b0};
                        r_e <= r_e - EXP_W'(1);
                    end
                end
                S_SQ: begin
                    if (sq[31]) begin
                        r_x      <= sq[31:1];
                        r_f[r_i] <= 1'b1;
                    end else begin
                        r_x      <= sq[30:0];
                        r_f[r_i] <= 1'b0;
                    end
                    if (r_i == 5'd0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_i <= r_i - 5'd1;
                    end
                end
                S_MUL: begin
                    r_prod  <= {32'd0, mag} * {27'd0, LN2_Q32};
                    r_neg   <= l2[26];
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_res   <= r_neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/lgal_back.sv =====
module lgal_back
    import lgal_pkg::*;
#(
    parameter int unsigned MAX_POPS    = MAX_POPS_DEF,
    parameter int unsigned MAX_ALLELES = MAX_ALLELES_DEF,
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int unsigned PW = (MAX_POPS > 1) ? $clog2(MAX_POPS) : 1,
    parameter int unsigned AW = $clog2(MAX_ALLELES),
    parameter int unsigned LW = $clog2(MAX_POPS * MAX_ALLELES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [THETA_W-1:0]        i_theta,
    input  logic                      i_q_valid,
    output logic                      o_q_pop,
    input  logic [PW-1:0]             i_q_pop_idx,
    input  logic [AW-1:0]             i_q_al_idx,
    input  logic [LW-1:0]             i_q_loc_idx,
    input  t_flags                    i_q_flags,
    output logic                      o_init_done,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [TERM_W-1:0]  o_term,
    output logic signed [TOTAL_W-1:0] o_running_total,
    output logic                      o_impossible,
    output logic                      o_final_result
);

    localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned NW     = (CW + 17 > MANT_W) ? CW + 17 : MANT_W;
    localparam int unsigned LDEPTH = MAX_POPS * MAX_ALLELES;
    localparam logic [CW-1:0] CMAX = CW'(MAX_SAMPLES);
    localparam logic [LW:0]   GLIM = (LW + 1)'(MAX_ALLELES);
    localparam logic [LW:0]   PLIM = (LW + 1)'(MAX_POPS);
    localparam logic [LW-1:0] CEND = LW'(LDEPTH - 1);
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = -(SUM_W'(1) <<< 33);
    localparam logic signed [TERM_W-1:0] TERM_MIN = -(TERM_W'(1) <<< 21);

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_CALC  = 11'b00000001000,
        S_LOGA  = 11'b00000010000,
        S_WAITA = 11'b00000100000,
        S_LOGB  = 11'b00001000000,
        S_WAITB = 11'b00010000000,
        S_UPD   = 11'b00100000000,
        S_SEED  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_bstate;

    t_bstate                r_state;
    logic                   r_seed;
    logic                   r_init_done;
    logic [LW-1:0]          r_clr;
    logic [PW-1:0]          r_pop;
    logic [AW-1:0]          r_al;
    logic [LW-1:0]          r_li;
    t_flags                 r_fl;

    logic [CW-1:0]          lc_mem [LDEPTH];
    logic [CW-1:0]          gc_mem [MAX_ALLELES];
    logic [CW-1:0]          ps_mem [MAX_POPS];
    logic [CW-1:0]          r_lc;
    logic [CW-1:0]          r_gc;
    logic [CW-1:0]          r_ps;
    logic [CW-1:0]          r_gt;

    logic [NW-1:0]          r_numer;
    logic [NW-1:0]          r_denom;
    logic                   r_skip;
    logic signed [LN_W-1:0] r_la;
    logic signed [LN_W-1:0] r_lb;
    logic signed [SUM_W-1:0] r_sum;
    logic                   r_imp;
    logic signed [TERM_W-1:0] r_term;

    logic                   r_out_valid;
    logic signed [TERM_W-1:0]  r_o_term;
    logic signed [TOTAL_W-1:0] r_o_total;
    logic                   r_o_imp;
    logic                   r_o_last;

    logic                   lg_start;
    logic [NW-1:0]          lg_value;
    logic                   lg_done;
    logic signed [LN_W-1:0] lg_result;

    logic [NW-1:0]          th;
    logic signed [LN_W:0]   t_raw;
    logic signed [TERM_W-1:0] t_clamp;
    logic signed [SUM_W-1:0]  s_next;
    logic                   lc_we;
    logic [LW-1:0]          lc_wa;
    logic [CW-1:0]          lc_wd;
    logic                   gc_we;
    logic [AW-1:0]          gc_wa;
    logic [CW-1:0]          gc_wd;
    logic                   ps_we;
    logic [PW-1:0]          ps_wa;
    logic [CW-1:0]          ps_wd;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c < CMAX) ? c + CW'(1) : c;
    endfunction

    lgal_log #(
        .NW (NW)
    ) u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lg_start),
        .i_value  (lg_value),
        .o_done   (lg_done),
        .o_result (lg_result)
    );

    assign lg_start = (r_state == S_LOGA) || (r_state == S_LOGB);
    assign lg_value = (r_state == S_LOGA) ? r_numer : r_denom;
    assign th       = (i_theta == '0) ? NW'(1) : NW'(i_theta);
    assign t_raw    = r_skip ? '0 : (LN_W + 1)'(r_la) - (LN_W + 1)'(r_lb);
    assign t_clamp  = (t_raw > 0) ? '0 :
                      (t_raw < (LN_W + 1)'(TERM_MIN)) ? TERM_MIN : TERM_W'(t_raw);
    assign s_next   = r_sum + SUM_W'(t_clamp);

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_init_done = r_init_done;

    always_comb begin
        lc_we = 1'b0;
        gc_we = 1'b0;
        ps_we = 1'b0;
        lc_wa = r_li;
        gc_wa = r_al;
        ps_wa = r_pop;
        lc_wd = sat_inc(r_lc);
        gc_wd = sat_inc(r_gc);
        ps_wd = sat_inc(r_ps);
        unique case (r_state)
            S_CLR: begin
                lc_we = 1'b1;
                gc_we = ({1'b0, r_clr} < GLIM);
                ps_we = ({1'b0, r_clr} < PLIM);
                lc_wa = r_clr;
                gc_wa = r_clr[AW-1:0];
                ps_wa = r_clr[PW-1:0];
                lc_wd = '0;
                gc_wd = '0;
                ps_wd = '0;
            end
            S_SEED: begin
                lc_we = 1'b1;
                gc_we = 1'b1;
                ps_we = 1'b1;
                lc_wd = CW'(1);
                gc_wd = CW'(1);
                ps_wd = CW'(1);
            end
            S_UPD: begin
                lc_we = 1'b1;
                gc_we = r_fl.is_global;
                ps_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lc_we) begin
            lc_mem[lc_wa] <= lc_wd;
        end
        r_lc <= lc_mem[r_li];
    end

    always_ff @(posedge i_clk) begin
        if (gc_we) begin
            gc_mem[gc_wa] <= gc_wd;
        end
        r_gc <= gc_mem[r_al];
    end

    always_ff @(posedge i_clk) begin
        if (ps_we) begin
            ps_mem[ps_wa] <= ps_wd;
        end
        r_ps <= ps_mem[r_pop];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_seed      <= 1'b0;
            r_init_done <= 1'b0;
            r_clr       <= '0;
            r_gt        <= '0;
            r_sum       <= '0;
            r_imp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_clr == CEND) begin
                        r_clr       <= '0;
                        r_init_done <= 1'b1;
                        r_state     <= r_seed ? S_SEED : S_IDLE;
                    end else begin
                        r_clr <= r_clr + LW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_pop   <= i_q_pop_idx;
                        r_al    <= i_q_al_idx;
                        r_li    <= i_q_loc_idx;
                        r_fl    <= i_q_flags;
                        r_seed  <= i_q_flags.first;
                        r_state <= i_q_flags.first ? S_CLR : S_RD;
                    end
                end
                S_RD: r_state <= S_CALC;
                S_CALC: begin
                    r_skip <= 1'b0;
                    if (r_fl.is_global) begin
                        r_numer <= (r_gc == '0) ? th : NW'({r_gc, 16'd0});
                        r_denom <= NW'({r_gt, 16'd0}) + th;
                        r_state <= S_LOGA;
                    end else if ((r_lc == '0) || (r_ps == '0)) begin
                        r_skip  <= 1'b1;
                        r_imp   <= 1'b1;
                        r_state <= S_UPD;
                    end else begin
                        r_numer <= NW'({r_lc, 16'd0});
                        r_denom <= NW'({r_ps, 16'd0});
                        r_state <= S_LOGA;
                    end
                end
                S_LOGA: r_state <= S_WAITA;
                S_WAITA: begin
                    if (lg_done) begin
                        r_la    <= lg_result;
                        r_state <= S_LOGB;
                    end
                end
                S_LOGB: r_state <= S_WAITB;
                S_WAITB: begin
                    if (lg_done) begin
                        r_lb    <= lg_result;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_fl.is_global) begin
                        r_gt <= sat_inc(r_gt);
                    end
                    r_term  <= t_clamp;
                    r_sum   <= (s_next < SUM_MIN) ? SUM_MIN : s_next;
                    r_state <= S_OUT;
                end
                S_SEED: begin
                    r_seed  <= 1'b0;
                    r_gt    <= CW'(1);
                    r_sum   <= '0;
                    r_imp   <= 1'b0;
                    r_term  <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_ready)) begin
            r_o_term  <= r_term;
            r_o_total <= r_sum[TOTAL_W-1:0];
            r_o_imp   <= r_imp;
            r_o_last  <= r_fl.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_term          = r_o_term;
    assign o_running_total = r_o_total;
    assign o_impossible    = r_o_imp;
    assign o_final_result  = r_o_last;

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lg_done |-> (r_state == S_WAITA) || (r_state == S_WAITB))
        else $error("log result with no waiting request");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_out_valid && !i_ready |=> (r_state == S_OUT))
        else $error("result overwrote pending transfer");

    a_imp_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_imp) |-> $past(r_state == S_CALC))
        else $error("impossible flag set outside classification");

    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_RD) || (r_state == S_CLR))
        else $error("queue pop without dispatch");

endmodule

// ===== hdl/local_global_allele_loglik_top.sv =====
// Per non-first sample: two passes through the shared log unit (normalizing
// shift, 20 squarings, multiply and round); a local copy of an unseen allele
// skips the log unit.
// First sample: a clear sweep over all MAX_POPS*MAX_ALLELES local counters runs first.
// Throughput: one sample at a time in the back end; a 2-entry queue buffers the front.
// Reset: synchronous active low; after reset a clear sweep of all MAX_POPS*MAX_ALLELES
// local counters runs with the input held not ready; theta resets to 1.0.
module local_global_allele_loglik_top
    import lgal_pkg::*;
#(
    parameter int unsigned MAX_POPS    = MAX_POPS_DEF,
    parameter int unsigned MAX_ALLELES = MAX_ALLELES_DEF,
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [THETA_W-1:0]        i_theta,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [POP_IN_W-1:0]       i_population,
    input  logic [AL_IN_W-1:0]        i_allele,
    input  logic                      i_is_global,
    input  logic                      i_first_item,
    input  logic                      i_last_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [TERM_W-1:0]  o_term,
    output logic signed [TOTAL_W-1:0] o_running_total,
    output logic                      o_impossible,
    output logic                      o_final_result
);

    localparam int unsigned PW = (MAX_POPS > 1) ? $clog2(MAX_POPS) : 1;
    localparam int unsigned AW = $clog2(MAX_ALLELES);
    localparam int unsigned LW = $clog2(MAX_POPS * MAX_ALLELES);

    logic [THETA_W-1:0] r_theta;
    logic               q_valid;
    logic               q_pop;
    logic [PW-1:0]      q_pop_idx;
    logic [AW-1:0]      q_al_idx;
    logic [LW-1:0]      q_loc_idx;
    t_flags             q_flags;
    logic               init_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= THETA_RESET;
        end else if (i_cfg_valid) begin
            r_theta <= i_theta;
        end
    end

    lgal_front #(
        .MAX_POPS    (MAX_POPS),
        .MAX_ALLELES (MAX_ALLELES),
        .PW          (PW),
        .AW          (AW),
        .LW          (LW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_population (i_population),
        .i_allele     (i_allele),
        .i_is_global  (i_is_global),
        .i_first_item (i_first_item),
        .i_last_item  (i_last_item),
        .i_enable     (init_done),
        .o_q_valid    (q_valid),
        .i_q_pop      (q_pop),
        .o_q_pop_idx  (q_pop_idx),
        .o_q_al_idx   (q_al_idx),
        .o_q_loc_idx  (q_loc_idx),
        .o_q_flags    (q_flags)
    );

    lgal_back #(
        .MAX_POPS    (MAX_POPS),
        .MAX_ALLELES (MAX_ALLELES),
        .MAX_SAMPLES (MAX_SAMPLES),
        .PW          (PW),
        .AW          (AW),
        .LW          (LW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_theta         (r_theta),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_pop_idx     (q_pop_idx),
        .i_q_al_idx      (q_al_idx),
        .i_q_loc_idx     (q_loc_idx),
        .i_q_flags       (q_flags),
        .o_init_done     (init_done),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_term          (o_term),
        .o_running_total (o_running_total),
        .o_impossible    (o_impossible),
        .o_final_result  (o_final_result)
    );

endmodule

// ===== test/local_global_allele_loglik_top_tb.sv =====
module local_global_allele_loglik_top_tb;
    import lgal_pkg::*;

    localparam int NPOP      = MAX_POPS_DEF;
    localparam int NAL       = MAX_ALLELES_DEF;
    localparam int CAP       = MAX_SAMPLES_DEF;
    localparam int WD_LIMIT  = 10000;
    localparam int DRAIN_GAP = 120;

    typedef struct {
        logic signed [TERM_W-1:0]  term;
        logic signed [TOTAL_W-1:0] total;
        logic                      impossible;
        logic                      final_result;
    } t_score;

    class allele_score_board;
        int unsigned               theta;
        int unsigned               local_cnt[NPOP*NAL];
        int unsigned               global_cnt[NAL];
        int unsigned               pop_size[NPOP];
        int unsigned               global_tot;
        longint                    log_sum;
        bit                        imp_seen;
        t_score                    scores_due[$];
        int                        errors;
        int                        n_seq;
        int                        n_imp;

        function new();
            theta = 32'(THETA_RESET);
            clear_counts();
            errors = 0;
            n_seq = 0;
            n_imp = 0;
        endfunction

        function void clear_counts();
            foreach (local_cnt[i]) local_cnt[i] = 0;
            foreach (global_cnt[i]) global_cnt[i] = 0;
            foreach (pop_size[i]) pop_size[i] = 0;
            global_tot = 0;
            log_sum = 0;
            imp_seen = 0;
        endfunction

        function int unsigned bump(int unsigned c);
            return (c < CAP) ? c + 1 : c;
        endfunction

        function longint ln_fx(longint unsigned v);
            int msb;
            longint unsigned x;
            longint unsigned mag;
            longint unsigned q;
            longint l2;
            if (v == 0) v = 1;
            msb = 63;
            while (v[msb] == 1'b0) msb--;
            if (msb <= 30) x = v << (30 - msb);
            else x = v >> (msb - 30);
            l2 = longint'(msb - 16) * 1048576;
            for (int i = 19; i >= 0; i--) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    l2 += longint'(1) << i;
                end
            end
            mag = (l2 < 0) ? longint'(-l2) : l2;
            q = (mag * 64'(LN2_Q32) + (64'd1 << 35)) >> 36;
            return (l2 < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_input(int unsigned p, int unsigned a, bit g, bit f, bit l);
            int unsigned li;
            longint trm;
            longint unsigned th;
            longint unsigned num;
            longint unsigned den;
            t_score s;
            li = p * NAL + a;
            trm = 0;
            if (f) begin
                clear_counts();
                global_cnt[a] = 1;
                local_cnt[li] = 1;
                pop_size[p] = 1;
                global_tot = 1;
                n_seq++;
            end else begin
                th = (theta == 0) ? 1 : theta;
                if (g) begin
                    den = (longint'(global_tot) << 16) + th;
                    num = (global_cnt[a] == 0) ? th : (longint'(global_cnt[a]) << 16);
                    trm = ln_fx(num) - ln_fx(den);
                    global_cnt[a] = bump(global_cnt[a]);
                    global_tot = bump(global_tot);
                end else if (local_cnt[li] == 0 || pop_size[p] == 0) begin
                    imp_seen = 1;
                    n_imp++;
                end else begin
                    trm = ln_fx(longint'(local_cnt[li]) << 16)
                        - ln_fx(longint'(pop_size[p]) << 16);
                end
                if (trm > 0) trm = 0;
                if (trm < -2097152) trm = -2097152;
                local_cnt[li] = bump(local_cnt[li]);
                pop_size[p] = bump(pop_size[p]);
                log_sum += trm;
                if (log_sum < -64'sd8589934592) log_sum = -64'sd8589934592;
            end
            s.term = trm[TERM_W-1:0];
            s.total = log_sum[TOTAL_W-1:0];
            s.impossible = imp_seen;
            s.final_result = l;
            scores_due.push_back(s);
        endfunction

        function void check_result(logic [TERM_W-1:0] t, logic [TOTAL_W-1:0] tot,
                                   logic imp, logic fin);
            t_score s;
            if (scores_due.size() == 0) begin
                $error("result with no expected score: term %0d", $signed(t));
                errors++;
                return;
            end
            s = scores_due.pop_front();
            if (t !== s.term) begin
                $error("term: expected %0d, actual %0d", s.term, $signed(t));
                errors++;
            end
            if (tot !== s.total) begin
                $error("running_total: expected %0d, actual %0d", s.total, $signed(tot));
                errors++;
            end
            if (imp !== s.impossible) begin
                $error("impossible: expected %0b, actual %0b", s.impossible, imp);
                errors++;
            end
            if (fin !== s.final_result) begin
                $error("final_result: expected %0b, actual %0b", s.final_result, fin);
                errors++;
            end
        endfunction

        function int pending();
            return scores_due.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [THETA_W-1:0]        i_theta;
    logic                      i_valid;
    logic                      o_ready;
    logic [POP_IN_W-1:0]       i_population;
    logic [AL_IN_W-1:0]        i_allele;
    logic                      i_is_global;
    logic                      i_first_item;
    logic                      i_last_item;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [TERM_W-1:0]  o_term;
    logic signed [TOTAL_W-1:0] o_running_total;
    logic                      o_impossible;
    logic                      o_final_result;

    allele_score_board sb;
    int  burst_left;
    bit  quiet;
    int  idle_cycles;
    int  n_sent;
    int  n_checked;
    int  theta_writes;

    local_global_allele_loglik_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_theta         (i_theta),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_population    (i_population),
        .i_allele        (i_allele),
        .i_is_global     (i_is_global),
        .i_first_item    (i_first_item),
        .i_last_item     (i_last_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_term          (o_term),
        .o_running_total (o_running_total),
        .o_impossible    (o_impossible),
        .o_final_result  (o_final_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_term, o_running_total, o_impossible, o_final_result);
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int mode;
        int span;
        i_ready = 1'b1;
        @(posedge i_clk);
        wait (i_rst_n);
        repeat (30000) @(posedge i_clk);
        i_ready <= 1'b0;
        repeat (700) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 400);
            repeat (span) begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 1);
                    2: i_ready <= ($urandom_range(0, 9) == 0);
                    default: i_ready <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send(input int unsigned p, input int unsigned a,
                        input bit g, input bit f, input bit l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_population <= POP_IN_W'(p);
        i_allele <= AL_IN_W'(a);
        i_is_global <= g;
        i_first_item <= f;
        i_last_item <= l;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(p, a, g, f, l);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_theta(input int unsigned v);
        drain();
        i_cfg_valid <= 1'b1;
        i_theta <= THETA_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.theta = v;
        theta_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_sequence(input int len);
        bit wide;
        int pmax;
        int amax;
        wide = ($urandom_range(0, 4) == 0);
        pmax = wide ? NPOP - 1 : $urandom_range(0, 3);
        amax = wide ? NAL - 1 : $urandom_range(0, 7);
        send($urandom_range(0, pmax), $urandom_range(0, amax),
             1'($urandom_range(0, 1)), 1'b1, len == 1);
        for (int k = 1; k < len; k++) begin
            if ($urandom_range(0, 19) == 0)
                send($urandom_range(0, NPOP-1), $urandom_range(0, NAL-1),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            else
                send($urandom_range(0, pmax), $urandom_range(0, amax),
                     $urandom_range(0, 2) != 0, 1'b0, k == len - 1);
        end
    endtask

    initial begin
        int unsigned th;
        int cnt;
        sb = new();
        burst_left = 0;
        quiet = 0;
        n_sent = 0;
        theta_writes = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_theta = '0;
        i_valid = 1'b0;
        i_population = '0;
        i_allele = '0;
        i_is_global = 1'b0;
        i_first_item = 1'b0;
        i_last_item = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(15, 63, 1'b1, 1'b0, 1'b0);
        send(0, 0, 1'b0, 1'b0, 1'b1);
        send(3, 5, 1'b1, 1'b0, 1'b0);
        send(0, 0, 1'b1, 1'b1, 1'b0);
        send(0, 0, 1'b1, 1'b0, 1'b0);
        send(0, 63, 1'b1, 1'b0, 1'b0);
        send(0, 0, 1'b0, 1'b0, 1'b0);
        send(15, 5, 1'b0, 1'b0, 1'b0);
        send(15, 5, 1'b0, 1'b0, 1'b1);
        send(15, 63, 1'b1, 1'b0, 1'b0);
        send(9, 42, 1'b1, 1'b1, 1'b1);
        send(9, 42, 1'b0, 1'b0, 1'b1);
        write_theta(24'hFFFFFF);
        send(1, 2, 1'b1, 1'b1, 1'b0);
        send(1, 3, 1'b1, 1'b0, 1'b0);
        send(1, 2, 1'b1, 1'b0, 1'b0);
        send(1, 2, 1'b0, 1'b0, 1'b1);
        write_theta(0);
        send(1, 2, 1'b1, 1'b1, 1'b0);
        send(1, 9, 1'b1, 1'b0, 1'b0);
        send(1, 9, 1'b0, 1'b0, 1'b1);
        write_theta(1);
        send(0, 1, 1'b1, 1'b1, 1'b0);
        send(0, 7, 1'b1, 1'b0, 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: th = 1;
                1: th = 24'hFFFFFF;
                2: th = THETA_RESET;
                default: th = $urandom_range(1, 24'hFFFFFF);
            endcase
            write_theta(th);
            quiet = (ph == 2);
            cnt = 0;
            while (cnt < 330) begin
                int len;
                len = $urandom_range(1, 40);
                random_sequence(len);
                cnt += len;
            end
        end

        drain();
        $display("Sent %0d samples in %0d sequences, %0d theta writes, %0d checked.",
                 n_sent, sb.n_seq, theta_writes, n_checked);
        $display("Covered unseen/seen/local/impossible terms, theta extremes and stalls.");
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lgal_pkg.sv
hdl/lgal_front.sv
hdl/lgal_log.sv
hdl/lgal_back.sv
hdl/local_global_allele_loglik_top.sv
test/local_global_allele_loglik_top_tb.sv
